// ===== hdl/assert_macros.svh =====
// assertion macros for the allocator top level
// depends on clk and rst_n being visible at the point of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VPA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpa assertion failed");

// next-cycle implication
`define VPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpa assertion failed");

`endif

// ===== hdl/vpa_pkg.sv =====
// types, codes and sizes for the variable partition allocator
// no dependencies
package vpa_pkg;

    localparam int MAX_SEGMENTS = 32;
    localparam int ADDR_BITS    = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int SIZE_W       = ADDR_BITS + 1;
    localparam int OWNER_W      = 8;
    localparam int PCT_W        = 7;
    localparam int NUM_W        = SIZE_W + PCT_W;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 17;
    localparam int PCT_SCALE    = 100;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;
    localparam logic [1:0] REQ_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MEM_TOTAL  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 1'd1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [16:0]        req_size;
        logic [OWNER_W-1:0] owner_id;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [15:0]      start_addr;
        logic [PCT_W-1:0] frag_percent;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
        logic                 free;
        logic [OWNER_W-1:0]   owner;
    } seg_t;

endpackage

// ===== hdl/vpa_frag_div.sv =====
// fragmentation percent: one multiply by 100, then a restoring divide one bit a cycle
// depends on vpa_pkg
module vpa_frag_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  logic [vpa_pkg::SIZE_W-1:0]  tot,
    input  logic [vpa_pkg::SIZE_W-1:0]  big,
    output logic                        done,
    output logic [vpa_pkg::PCT_W-1:0]   pct
);

    logic                        run_reg, run_next;
    logic                        done_reg, done_next;
    logic [2:0]                  step_reg, step_next;
    logic [vpa_pkg::NUM_W-1:0]   rem_reg, rem_next;
    logic [vpa_pkg::NUM_W-1:0]   dsh_reg, dsh_next;
    logic [vpa_pkg::PCT_W-1:0]   q_reg, q_next;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (go)
        begin
            q_next   = '0;
            rem_next = vpa_pkg::NUM_W'(tot - big) * vpa_pkg::NUM_W'(vpa_pkg::PCT_SCALE);
            dsh_next = vpa_pkg::NUM_W'(tot) << (vpa_pkg::PCT_W - 1);
            step_next = 3'(vpa_pkg::PCT_W - 1);
            if (tot == '0)
            begin
                done_next = 1'b1;
            end
            else
            begin
                run_next = 1'b1;
            end
        end
        else if (run_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_next = rem_reg - dsh_reg;
                q_next[step_reg] = 1'b1;
            end
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 3'd1;
            if (step_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            q_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
            q_reg    <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
    end

    assign done = done_reg;
    assign pct  = q_reg;

endmodule

// ===== hdl/variable_partition_allocator.sv =====
// variable partition allocator top level: segment table memory and pass sequencer
// depends on vpa_pkg, vpa_frag_div and assert_macros.svh
//
// usage: raise start with a request on req while busy is low; the request is
// taken at that edge and busy stays high until the answer. the answer appears
// on rsp and is held there; done is high for exactly one cycle and the receiver
// cannot stall it. config writes (cfg_we, cfg_idx, cfg_data) must go in only
// while busy is low; the block does not enforce it. writing memory_total resets
// the table to one free segment. each request walks the table of n segments
// one entry a cycle through the single read port of the table memory:
//   allocate: scan, shift up and split if the pick is larger, take, frag pass
//   free, compact: one merge pass, then the frag pass
//   query: the frag pass only
// the frag pass sums free segments, then multiplies and divides bit-serially;
// pct is 0 when nothing is free. a zero-size or unfit allocate, or one needing
// a split in a full table, skips to it. n is up to 32; done rises as busy falls.
// after reset the table holds one free segment of 65536 units, first fit.
`include "assert_macros.svh"
module variable_partition_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  vpa_pkg::req_t                   req,
    output logic                            done,
    output vpa_pkg::rsp_t                   rsp,
    input  logic                            cfg_we,
    input  logic [vpa_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [vpa_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = vpa_pkg::IDX_W;
    localparam int CW = vpa_pkg::CNT_W;
    localparam int SW = vpa_pkg::SIZE_W;
    localparam int AW = vpa_pkg::ADDR_BITS;
    localparam logic [SW-1:0] MEM_LIMIT = SW'(64'(1) << AW);
    localparam logic [CW-1:0] MAX_CNT   = CW'(vpa_pkg::MAX_SEGMENTS);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_SHIFT   = 4'd2;
    localparam logic [3:0] S_SPLIT   = 4'd3;
    localparam logic [3:0] S_TAKE    = 4'd4;
    localparam logic [3:0] S_FREE    = 4'd5;
    localparam logic [3:0] S_COMPACT = 4'd6;
    localparam logic [3:0] S_FSCAN   = 4'd7;
    localparam logic [3:0] S_FRAG    = 4'd8;
    localparam logic [3:0] S_WAIT    = 4'd9;

    vpa_pkg::seg_t mem [vpa_pkg::MAX_SEGMENTS];
    vpa_pkg::seg_t rd_q_reg;

    logic [3:0]                  state_reg, state_next;
    logic [CW-1:0]               iss_reg, iss_next;
    logic                        dval_reg, dval_next;
    logic [IW-1:0]               didx_reg, didx_next;
    logic                        ovr_reg, ovr_next;
    logic                        init_reg, init_next;
    logic [CW-1:0]               seg_count_reg, seg_count_next;
    logic                        found_reg, found_next;
    logic                        hv_reg, hv_next;
    logic [CW-1:0]               w_reg, w_next;
    logic [SW-1:0]               mem_total_reg, mem_total_next;
    logic [1:0]                  fit_reg, fit_next;
    logic                        done_reg, done_next;
    vpa_pkg::rsp_t               rsp_reg, rsp_next;

    vpa_pkg::req_t               req_reg, req_next;
    logic [IW-1:0]               pick_idx_reg, pick_idx_next;
    vpa_pkg::seg_t               pick_reg, pick_next;
    vpa_pkg::seg_t               hold_reg, hold_next;
    logic [SW-1:0]               pos_reg, pos_next;
    logic [SW-1:0]               tot_reg, tot_next;
    logic [SW-1:0]               big_reg, big_next;
    logic [1:0]                  status_reg, status_next;
    logic [AW-1:0]               addr_reg, addr_next;

    logic                        rd_en;
    logic [IW-1:0]               rd_addr;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    vpa_pkg::seg_t               wr_data;
    logic [SW-1:0]               eff_total;
    vpa_pkg::seg_t               cur;
    vpa_pkg::seg_t               e;
    logic                        fits;
    logic                        div_go;
    logic                        div_done;
    logic [vpa_pkg::PCT_W-1:0]   div_pct;

    always_comb
    begin
        if (mem_total_reg == '0)
        begin
            eff_total = SW'(1);
        end
        else if (mem_total_reg > MEM_LIMIT)
        begin
            eff_total = MEM_LIMIT;
        end
        else
        begin
            eff_total = mem_total_reg;
        end
    end

    always_comb
    begin
        if (ovr_reg)
        begin
            cur.start = '0;
            cur.size  = eff_total;
            cur.free  = 1'b1;
            cur.owner = '0;
        end
        else
        begin
            cur = rd_q_reg;
        end
    end

    assign fits = cur.free && (cur.size >= req_reg.req_size);

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        dval_next      = 1'b0;
        didx_next      = didx_reg;
        ovr_next       = 1'b0;
        init_next      = init_reg;
        seg_count_next = seg_count_reg;
        found_next     = found_reg;
        hv_next        = hv_reg;
        w_next         = w_reg;
        mem_total_next = mem_total_reg;
        fit_next       = fit_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        req_next       = req_reg;
        pick_idx_next  = pick_idx_reg;
        pick_next      = pick_reg;
        hold_next      = hold_reg;
        pos_next       = pos_reg;
        tot_next       = tot_reg;
        big_next       = big_reg;
        status_next    = status_reg;
        addr_next      = addr_reg;
        rd_en          = 1'b0;
        rd_addr        = iss_reg[IW-1:0];
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = cur;
        div_go         = 1'b0;
        e              = cur;

        // read issue for the table passes
        unique case (state_reg)
            S_SCAN, S_FREE, S_COMPACT, S_FSCAN:
            begin
                rd_en    = iss_reg < seg_count_reg;
                iss_next = rd_en ? iss_reg + CW'(1) : iss_reg;
            end
            S_SHIFT:
            begin
                rd_en    = iss_reg > CW'(pick_idx_reg);
                iss_next = rd_en ? iss_reg - CW'(1) : iss_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
        dval_next = rd_en;
        didx_next = iss_reg[IW-1:0];
        ovr_next  = rd_en && (rd_addr == '0) && init_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = req;
                    status_next = vpa_pkg::ST_OK;
                    addr_next   = '0;
                    iss_next    = '0;
                    found_next  = 1'b0;
                    hv_next     = 1'b0;
                    w_next      = '0;
                    pos_next    = '0;
                    tot_next    = '0;
                    big_next    = '0;
                    unique case (req.req_type)
                        vpa_pkg::REQ_ALLOC:
                        begin
                            if (req.req_size == '0)
                            begin
                                status_next = vpa_pkg::ST_NOFIT;
                                state_next  = S_FSCAN;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        vpa_pkg::REQ_FREE:    state_next = S_FREE;
                        vpa_pkg::REQ_COMPACT: state_next = S_COMPACT;
                        default:              state_next = S_FSCAN;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (dval_reg)
                begin
                    priority if (fit_reg == vpa_pkg::FIT_BEST)
                    begin
                        if (fits && (!found_reg || cur.size < pick_reg.size))
                        begin
                            found_next = 1'b1;
                            pick_next = cur;
                            pick_idx_next = didx_reg;
                        end
                    end
                    else if (fit_reg == vpa_pkg::FIT_WORST)
                    begin
                        if (fits && (!found_reg || cur.size > pick_reg.size))
                        begin
                            found_next = 1'b1;
                            pick_next = cur;
                            pick_idx_next = didx_reg;
                        end
                    end
                    else
                    begin
                        if (fits && !found_reg)
                        begin
                            found_next = 1'b1;
                            pick_next = cur;
                            pick_idx_next = didx_reg;
                        end
                    end
                end
                else if (!rd_en)
                begin
                    iss_next = '0;
                    if (!found_reg)
                    begin
                        status_next = vpa_pkg::ST_NOFIT;
                        state_next  = S_FSCAN;
                    end
                    else if (pick_reg.size > req_reg.req_size)
                    begin
                        if (seg_count_reg >= MAX_CNT)
                        begin
                            status_next = vpa_pkg::ST_FULL;
                            state_next  = S_FSCAN;
                        end
                        else
                        begin
                            iss_next   = seg_count_reg - CW'(1);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        state_next = S_TAKE;
                    end
                end
            end
            S_SHIFT:
            begin
                if (dval_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = didx_reg + IW'(1);
                    wr_data = cur;
                end
                else if (!rd_en)
                begin
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                wr_en          = 1'b1;
                wr_addr        = pick_idx_reg + IW'(1);
                wr_data.start  = pick_reg.start + req_reg.req_size[AW-1:0];
                wr_data.size   = pick_reg.size - req_reg.req_size;
                wr_data.free   = 1'b1;
                wr_data.owner  = '0;
                seg_count_next = seg_count_reg + CW'(1);
                state_next     = S_TAKE;
            end
            S_TAKE:
            begin
                wr_en         = 1'b1;
                wr_addr       = pick_idx_reg;
                wr_data.start = pick_reg.start;
                wr_data.size  = req_reg.req_size;
                wr_data.free  = 1'b0;
                wr_data.owner = req_reg.owner_id;
                addr_next     = pick_reg.start;
                iss_next      = '0;
                state_next    = S_FSCAN;
            end
            S_FREE:
            begin
                if (dval_reg)
                begin
                    if (!cur.free && (cur.owner == req_reg.owner_id))
                    begin
                        e.free  = 1'b1;
                        e.owner = '0;
                    end
                    if (hv_reg && hold_reg.free && e.free)
                    begin
                        hold_next.size = hold_reg.size + e.size;
                    end
                    else
                    begin
                        if (hv_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = w_reg[IW-1:0];
                            wr_data = hold_reg;
                            w_next  = w_reg + CW'(1);
                        end
                        hold_next = e;
                        hv_next   = 1'b1;
                    end
                end
                else if (!rd_en)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = w_reg[IW-1:0];
                    wr_data        = hold_reg;
                    seg_count_next = w_reg + CW'(1);
                    iss_next       = '0;
                    state_next     = S_FSCAN;
                end
            end
            S_COMPACT:
            begin
                if (dval_reg)
                begin
                    if (!cur.free)
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = w_reg[IW-1:0];
                        wr_data.start = pos_reg[AW-1:0];
                        wr_data.size  = cur.size;
                        wr_data.free  = 1'b0;
                        wr_data.owner = cur.owner;
                        pos_next      = pos_reg + cur.size;
                        w_next        = w_reg + CW'(1);
                    end
                end
                else if (!rd_en)
                begin
                    // trailing free segment
                    if ((pos_reg < eff_total) && (w_reg < MAX_CNT))
                    begin
                        wr_en          = 1'b1;
                        wr_addr        = w_reg[IW-1:0];
                        wr_data.start  = pos_reg[AW-1:0];
                        wr_data.size   = eff_total - pos_reg;
                        wr_data.free   = 1'b1;
                        wr_data.owner  = '0;
                        seg_count_next = w_reg + CW'(1);
                    end
                    else
                    begin
                        seg_count_next = w_reg;
                    end
                    iss_next   = '0;
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN:
            begin
                if (dval_reg)
                begin
                    if (cur.free)
                    begin
                        tot_next = tot_reg + cur.size;
                        if (cur.size > big_reg)
                        begin
                            big_next = cur.size;
                        end
                    end
                end
                else if (!rd_en)
                begin
                    state_next = S_FRAG;
                end
            end
            S_FRAG:
            begin
                div_go     = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    rsp_next.status       = status_reg;
                    rsp_next.start_addr   = addr_reg;
                    rsp_next.frag_percent = div_pct;
                    done_next             = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en && (wr_addr == '0))
        begin
            init_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_idx)
                vpa_pkg::CFG_MEM_TOTAL:
                begin
                    mem_total_next = cfg_data;
                    init_next      = 1'b1;
                    seg_count_next = CW'(1);
                end
                default:
                begin
                    fit_next = cfg_data[1:0];
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_reg       <= '0;
            dval_reg      <= 1'b0;
            didx_reg      <= '0;
            ovr_reg       <= 1'b0;
            init_reg      <= 1'b1;
            seg_count_reg <= CW'(1);
            found_reg     <= 1'b0;
            hv_reg        <= 1'b0;
            w_reg         <= '0;
            mem_total_reg <= MEM_LIMIT;
            fit_reg       <= '0;
            done_reg      <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            dval_reg      <= dval_next;
            didx_reg      <= didx_next;
            ovr_reg       <= ovr_next;
            init_reg      <= init_next;
            seg_count_reg <= seg_count_next;
            found_reg     <= found_next;
            hv_reg        <= hv_next;
            w_reg         <= w_next;
            mem_total_reg <= mem_total_next;
            fit_reg       <= fit_next;
            done_reg      <= done_next;
            rsp_reg       <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pick_idx_reg <= pick_idx_next;
        pick_reg     <= pick_next;
        hold_reg     <= hold_next;
        pos_reg      <= pos_next;
        tot_reg      <= tot_next;
        big_reg      <= big_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
    end

    vpa_frag_div u_frag_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .tot   (tot_reg),
        .big   (big_reg),
        .done  (div_done),
        .pct   (div_pct)
    );

    assign busy = state_reg != S_IDLE;
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `VPA_ASSERT_IMP(a_done_idle, done, !busy)
    `VPA_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    `VPA_ASSERT_IMP(a_count_range, busy, (seg_count_reg != '0) && (seg_count_reg <= MAX_CNT))
    `VPA_ASSERT_IMP(a_fail_addr, done && (rsp.status != vpa_pkg::ST_OK), rsp.start_addr == '0)

endmodule
